[rtl/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checked at every edge, reset included.
`define E2Q_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
// Checked outside reset.
`define E2Q_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`endif

[rtl/e2q_pkg.sv]
// Types, constants and the CORDIC angle table for the Euler to quaternion block.
`default_nettype none
package e2q_pkg;
  localparam int ANGLE_WIDTH  = 16;
  localparam int CORDIC_STEPS = 30;
  localparam int XW           = 33;
  localparam int ZW           = 35;
  localparam logic signed [XW-1:0] CORDIC_INIT = 33'sd652032874;

  typedef struct packed {
    logic signed [15:0] heading_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] bank_angle;
    logic               inverse_dir;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } out_word_t;

  function automatic logic signed [ZW-1:0] atan_step(input int idx);
    logic [31:0] a;
    case (idx)
      0:  a = 32'h20000000;
      1:  a = 32'h12E4051E;
      2:  a = 32'h09FB385B;
      3:  a = 32'h051111D4;
      4:  a = 32'h028B0D43;
      5:  a = 32'h0145D7E1;
      6:  a = 32'h00A2F61E;
      7:  a = 32'h00517C55;
      8:  a = 32'h0028BE53;
      9:  a = 32'h00145F2F;
      10: a = 32'h000A2F98;
      11: a = 32'h000517CC;
      12: a = 32'h00028BE6;
      13: a = 32'h000145F3;
      14: a = 32'h0000A2FA;
      15: a = 32'h0000517D;
      16: a = 32'h000028BE;
      17: a = 32'h0000145F;
      18: a = 32'h00000A30;
      19: a = 32'h00000518;
      20: a = 32'h0000028C;
      21: a = 32'h00000146;
      22: a = 32'h000000A3;
      23: a = 32'h00000051;
      24: a = 32'h00000029;
      25: a = 32'h00000014;
      26: a = 32'h0000000A;
      27: a = 32'h00000005;
      28: a = 32'h00000003;
      29: a = 32'h00000001;
      default: a = 32'h0;
    endcase
    return $signed({{(ZW-33){1'b0}}, a, 1'b0});
  endfunction
endpackage
`default_nettype wire

[rtl/e2q_cordic.sv]
// Pipelined rotation-mode CORDIC giving sine and cosine of a half angle.
`default_nettype none
module e2q_cordic (
  input  wire logic                                 clk,
  input  wire logic                                 en,
  input  wire logic signed [e2q_pkg::ANGLE_WIDTH-1:0] angle,
  output logic signed [e2q_pkg::XW-1:0]             sin_o,
  output logic signed [e2q_pkg::XW-1:0]             cos_o
);
  localparam int N  = e2q_pkg::CORDIC_STEPS;
  localparam int XW = e2q_pkg::XW;
  localparam int ZW = e2q_pkg::ZW;

  logic signed [XW-1:0] x_r [0:N];
  logic signed [XW-1:0] y_r [0:N];
  logic signed [ZW-1:0] z_r [0:N];

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= e2q_pkg::CORDIC_INIT;
      y_r[0] <= '0;
      z_r[0] <= ZW'($signed(angle)) <<< (32 - e2q_pkg::ANGLE_WIDTH);
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[i][ZW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - e2q_pkg::atan_step(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + e2q_pkg::atan_step(i);
        end
      end
    end
  end

  assign sin_o = y_r[N];
  assign cos_o = x_r[N];
endmodule
`default_nettype wire

[rtl/euler_to_quaternion.sv]
// Top level: heading, pitch and bank angles to a Q1.FRAC_BITS unit quaternion.
//   channel | ports                      | carries
//   input   | in_valid in_stall in_word  | three binary angles, direction flag
//   output  | out_valid out_stall out_word | quaternion w x y z
// One word accepted per cycle unless the output stalls; 31 CORDIC stages, two
// multiplier stages, one round/clamp stage that is the output register.
// Reset clears the valid bits only; the datapath registers are not reset.
// A stalled output freezes the whole pipeline; in_stall follows out_stall
// only while the output register holds a word.
`default_nettype none
`include "assert_macros.svh"
module euler_to_quaternion #(
  parameter int FRAC_BITS = 14
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire e2q_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output e2q_pkg::out_word_t      out_word
);
  localparam int XW  = e2q_pkg::XW;
  localparam int LAT = e2q_pkg::CORDIC_STEPS + 4;
  localparam int PW  = 2 * XW - 30;
  localparam int TW  = PW + XW - 30;
  localparam int SW  = TW + 1;
  localparam logic signed [SW-1:0] LIM = SW'(1) <<< FRAC_BITS;

  logic en;
  logic vld_r [0:LAT-1];
  logic inv_r [0:LAT-1];

  assign en       = !vld_r[LAT-1] || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < LAT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inv_r[0] <= in_word.inverse_dir;
      for (int k = 1; k < LAT; k++) inv_r[k] <= inv_r[k-1];
    end
  end

  logic signed [XW-1:0] sh, ch, sp, cp, sb, cb;

  e2q_cordic u_head (.clk, .en, .angle(in_word.heading_angle), .sin_o(sh), .cos_o(ch));
  e2q_cordic u_pitch(.clk, .en, .angle(in_word.pitch_angle),   .sin_o(sp), .cos_o(cp));
  e2q_cordic u_bank (.clk, .en, .angle(in_word.bank_angle),    .sin_o(sb), .cos_o(cb));

  logic signed [2*XW-1:0] m_cc, m_ss, m_cs, m_sc;
  logic signed [PW-1:0]   cc_r, ss_r, cs_r, sc_r;
  logic signed [XW-1:0]   sb_r, cb_r;

  assign m_cc = ch * cp;
  assign m_ss = sh * sp;
  assign m_cs = ch * sp;
  assign m_sc = sh * cp;

  always_ff @(posedge clk) begin
    if (en) begin
      cc_r <= m_cc[2*XW-1:30];
      ss_r <= m_ss[2*XW-1:30];
      cs_r <= m_cs[2*XW-1:30];
      sc_r <= m_sc[2*XW-1:30];
      sb_r <= sb;
      cb_r <= cb;
    end
  end

  logic signed [PW+XW-1:0] t_w0, t_w1, t_x0, t_x1, t_y0, t_y1, t_z0, t_z1;
  logic signed [TW-1:0]    w0_r, w1_r, x0_r, x1_r, y0_r, y1_r, z0_r, z1_r;

  assign t_w0 = cc_r * cb_r;
  assign t_w1 = ss_r * sb_r;
  assign t_x0 = cs_r * cb_r;
  assign t_x1 = sc_r * sb_r;
  assign t_y0 = sc_r * cb_r;
  assign t_y1 = cs_r * sb_r;
  assign t_z0 = cc_r * sb_r;
  assign t_z1 = ss_r * cb_r;

  always_ff @(posedge clk) begin
    if (en) begin
      w0_r <= t_w0[PW+XW-1:30];
      w1_r <= t_w1[PW+XW-1:30];
      x0_r <= t_x0[PW+XW-1:30];
      x1_r <= t_x1[PW+XW-1:30];
      y0_r <= t_y0[PW+XW-1:30];
      y1_r <= t_y1[PW+XW-1:30];
      z0_r <= t_z0[PW+XW-1:30];
      z1_r <= t_z1[PW+XW-1:30];
    end
  end

  logic signed [SW-1:0] s_w, s_x, s_y, s_z;
  logic signed [SW-1:0] r_w, r_x, r_y, r_z;
  logic signed [SW-1:0] c_w, c_x, c_y, c_z;
  logic                 neg;

  assign s_w = SW'(w0_r) + SW'(w1_r);
  assign s_x = SW'(x0_r) + SW'(x1_r);
  assign s_y = SW'(y0_r) - SW'(y1_r);
  assign s_z = SW'(z0_r) - SW'(z1_r);

  if (FRAC_BITS < 30) begin : g_rnd
    localparam int RS = 30 - FRAC_BITS;
    localparam logic signed [SW-1:0] HALF = SW'(1) <<< (RS - 1);
    assign r_w = (s_w + HALF) >>> RS;
    assign r_x = (s_x + HALF) >>> RS;
    assign r_y = (s_y + HALF) >>> RS;
    assign r_z = (s_z + HALF) >>> RS;
  end else begin : g_nornd
    assign r_w = s_w;
    assign r_x = s_x;
    assign r_y = s_y;
    assign r_z = s_z;
  end

  function automatic logic signed [SW-1:0] clamp(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    r = v;
    if (v > LIM) r = LIM;
    if (v < -LIM) r = -LIM;
    return r;
  endfunction

  assign neg = inv_r[LAT-2];
  assign c_w = clamp(r_w);
  assign c_x = neg ? -clamp(r_x) : clamp(r_x);
  assign c_y = neg ? -clamp(r_y) : clamp(r_y);
  assign c_z = neg ? -clamp(r_z) : clamp(r_z);

  e2q_pkg::out_word_t out_r;

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.quat_w <= c_w[15:0];
      out_r.quat_x <= c_x[15:0];
      out_r.quat_y <= c_y[15:0];
      out_r.quat_z <= c_z[15:0];
    end
  end

  assign out_valid = vld_r[LAT-1];
  assign out_word  = out_r;

  logic w_in_range;

  assign w_in_range = (out_word.quat_w <= 16'(LIM)) && (out_word.quat_w >= -16'(LIM));

  `E2Q_ASSERT(a_rst_clears, !rst_n |=> !out_valid, "output valid after reset")
  `E2Q_ASSERT_RUN(a_stall_rule, in_stall == (out_valid && out_stall), "input stall mismatch")
  `E2Q_ASSERT_RUN(a_w_range, (out_valid && FRAC_BITS < 15) |-> w_in_range, "w out of range")
  `E2Q_ASSERT_RUN(a_hold, (out_valid && out_stall) |=> $stable(vld_r[LAT-2]), "pipeline moved")
endmodule
`default_nettype wire

[dv/tb_euler_to_quaternion.sv]
// Testbench for euler_to_quaternion: random and directed angles against a CORDIC predictor.
`default_nettype none
module tb_euler_to_quaternion;

  localparam int FRAC = 14;
  localparam int LATENCY = 34;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  e2q_pkg::in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  e2q_pkg::out_word_t out_word;

  e2q_pkg::out_word_t quat_q[$];
  int errors = 0;
  longint cycles = 0;
  bit stall_on = 1'b1;

  euler_to_quaternion #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  always #5 clk = ~clk;

  function automatic longint atan_entry(input int i);
    longint t[30] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
      64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
      64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001};
    return t[i];
  endfunction

  function automatic void half_sin_cos(input logic signed [15:0] ang,
                                       output longint s, output longint c);
    longint x, y, z, dx, dy;
    x = 652032874;
    y = 0;
    z = longint'(ang) * 65536;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= 2 * atan_entry(i);
      end else begin
        x += dx; y -= dy; z += 2 * atan_entry(i);
      end
    end
    s = y;
    c = x;
  endfunction

  function automatic longint triple(input longint a, input longint b, input longint c);
    return (((a * b) >>> 30) * c) >>> 30;
  endfunction

  function automatic logic signed [15:0] round_clamp(input longint v);
    longint lim;
    lim = longint'(1) << FRAC;
    v = (v + (longint'(1) << (29 - FRAC))) >>> (30 - FRAC);
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v[15:0];
  endfunction

  function automatic e2q_pkg::out_word_t predict_quat(input e2q_pkg::in_word_t w);
    longint sh, ch, sp, cp, sb, cb;
    e2q_pkg::out_word_t q;
    half_sin_cos(w.heading_angle, sh, ch);
    half_sin_cos(w.pitch_angle, sp, cp);
    half_sin_cos(w.bank_angle, sb, cb);
    q.quat_w = round_clamp(triple(ch, cp, cb) + triple(sh, sp, sb));
    q.quat_x = round_clamp(triple(ch, sp, cb) + triple(sh, cp, sb));
    q.quat_y = round_clamp(triple(sh, cp, cb) - triple(ch, sp, sb));
    q.quat_z = round_clamp(triple(ch, cp, sb) - triple(sh, sp, cb));
    if (w.inverse_dir) begin
      q.quat_x = -q.quat_x; q.quat_y = -q.quat_y; q.quat_z = -q.quat_z;
    end
    return q;
  endfunction

  function automatic e2q_pkg::in_word_t rand_word();
    e2q_pkg::in_word_t w;
    w.heading_angle = 16'($urandom());
    w.pitch_angle = 16'($urandom());
    w.bank_angle = 16'($urandom());
    w.inverse_dir = 1'($urandom_range(0, 1));
    return w;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("euler_to_quaternion verification failed");
      $finish;
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (!stall_on) out_stall <= 1'b0;
    else case ($urandom_range(0, 7))
      0, 1: out_stall <= 1'b1;
      2: out_stall <= ($urandom_range(0, 3) == 0) ? 1'b1 : out_stall;
      default: out_stall <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    e2q_pkg::out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (quat_q.size() == 0) begin
        report_mismatch("unexpected word", 0, 0);
      end else begin
        want = quat_q.pop_front();
        if (out_word.quat_w !== want.quat_w)
          report_mismatch("quat_w", int'(out_word.quat_w), int'(want.quat_w));
        if (out_word.quat_x !== want.quat_x)
          report_mismatch("quat_x", int'(out_word.quat_x), int'(want.quat_x));
        if (out_word.quat_y !== want.quat_y)
          report_mismatch("quat_y", int'(out_word.quat_y), int'(want.quat_y));
        if (out_word.quat_z !== want.quat_z)
          report_mismatch("quat_z", int'(out_word.quat_z), int'(want.quat_z));
      end
    end
  end

  task automatic send_word(input e2q_pkg::in_word_t w);
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    quat_q.push_back(predict_quat(w));
  endtask

  task automatic idle_gap();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  task automatic send_angles(input int h, input int p, input int b, input bit inv);
    e2q_pkg::in_word_t w;
    w.heading_angle = h[15:0];
    w.pitch_angle = p[15:0];
    w.bank_angle = b[15:0];
    w.inverse_dir = inv;
    send_word(w);
  endtask

  task automatic test_extremes();
    int vals[6] = '{-32768, 32767, 0, 16384, -16384, 1};
    for (int i = 0; i < 6; i++) begin
      send_angles(vals[i], vals[(i + 1) % 6], vals[(i + 2) % 6], i[0]);
      send_angles(vals[i], vals[i], vals[i], ~i[0]);
    end
    send_angles(-32768, -32768, -32768, 1'b1);
    send_angles(32767, 32767, 32767, 1'b0);
    send_angles(0, 0, 0, 1'b1);
    send_angles(-1, -1, -1, 1'b0);
    idle_gap();
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (quat_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_random(input int count);
    int left;
    e2q_pkg::in_word_t w;
    left = count;
    while (left > 0) begin
      for (int n = $urandom_range(1, 40); n > 0 && left > 0; n--) begin
        w = rand_word();
        if ($urandom_range(0, 9) == 0)
          w.heading_angle = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
        send_word(w);
        left--;
      end
      if ($urandom_range(0, 2) == 0) idle_gap();
    end
    in_valid <= 1'b0;
  endtask

  task automatic test_no_stall(input int count);
    stall_on = 1'b0;
    for (int i = 0; i < count; i++) send_word(rand_word());
    in_valid <= 1'b0;
    stall_on = 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    drain_results();
    test_random(1000);
    drain_results();
    test_no_stall(250);
    drain_results();
    repeat (LATENCY * 2) @(posedge clk);
    if (errors == 0 && quat_q.size() == 0) begin
      $display("euler_to_quaternion verification clean");
    end else begin
      $display("euler_to_quaternion verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
